>>> hdl/distance_frame_parser_monitor_assert.svh
// Assertion macros for the distance frame parser monitor.
`ifndef DISTANCE_FRAME_PARSER_MONITOR_ASSERT_SVH
`define DISTANCE_FRAME_PARSER_MONITOR_ASSERT_SVH

`ifndef SYNTHESIS
`define DFPM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dfpm assertion failed");
`define DFPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dfpm assertion failed");
`else
`define DFPM_ASSERT_SAME(label, clk, rst, ante, cons)
`define DFPM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> hdl/dfpm_pkg.sv
package dfpm_pkg;

   localparam logic [7:0]  HEADER_BYTE = 8'hFF;
   localparam logic [15:0] AGE_MAX     = 16'hFFFF;

   // item kinds
   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   // register indexes
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_DISTANCE_MIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISTANCE_MAX  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_AGE       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HEALTH_TMO    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CLOSE_THRESH  = 3'd4;

   // register reset values
   localparam logic [15:0] DISTANCE_MIN_RST  = 16'd30;
   localparam logic [15:0] DISTANCE_MAX_RST  = 16'd4500;
   localparam logic [15:0] MAX_AGE_RST       = 16'd200;
   localparam logic [15:0] HEALTH_TMO_RST    = 16'd500;
   localparam logic [15:0] CLOSE_THRESH_RST  = 16'd0;

   typedef struct packed {
      logic       req_type;
      logic [7:0] byte_value;
   } req_type_type;

   typedef struct packed {
      logic [15:0] distance;
      logic        fresh;
      logic        too_close;
      logic        healthy;
      logic        frame_accepted;
      logic [31:0] drop_count;
   } rsp_type;

   typedef struct packed {
      logic [15:0] distance_min;
      logic [15:0] distance_max;
      logic [15:0] max_age_ticks;
      logic [15:0] health_timeout_ticks;
      logic [15:0] close_threshold;
   } cfg_type;

endpackage

>>> hdl/distance_frame_parser_monitor.sv
// An accepted transaction's result is registered into the result register, or into the skid
// if it is stalled; it then shows on rsp_. One transaction per cycle while req_stall is low;
// the parser state and flag compares sit between input handshake and result register.
// A two-entry output (result register plus skid) keeps input flowing for one stalled result.
// Reset is synchronous, active high: parser state cleared, registers to their defaults.
`include "distance_frame_parser_monitor_assert.svh"

module distance_frame_parser_monitor (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  dfpm_pkg::req_type_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output dfpm_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dfpm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [15:0]                         csr_wdata
);

   dfpm_pkg::cfg_type cfg_ff;
   dfpm_pkg::rsp_type result;
   dfpm_pkg::rsp_type rsp_data_ff;
   dfpm_pkg::rsp_type skid_data_ff;
   logic              rsp_valid_ff;
   logic              skid_valid_ff;
   logic              req_accept;
   logic              rsp_take;
   logic              csr_write;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign rsp_take   = rsp_valid_ff && !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.distance_min         <= dfpm_pkg::DISTANCE_MIN_RST;
         cfg_ff.distance_max         <= dfpm_pkg::DISTANCE_MAX_RST;
         cfg_ff.max_age_ticks        <= dfpm_pkg::MAX_AGE_RST;
         cfg_ff.health_timeout_ticks <= dfpm_pkg::HEALTH_TMO_RST;
         cfg_ff.close_threshold      <= dfpm_pkg::CLOSE_THRESH_RST;
      end else if (csr_write) begin
         case (csr_index)
            dfpm_pkg::CSR_DISTANCE_MIN: cfg_ff.distance_min         <= csr_wdata;
            dfpm_pkg::CSR_DISTANCE_MAX: cfg_ff.distance_max         <= csr_wdata;
            dfpm_pkg::CSR_MAX_AGE:      cfg_ff.max_age_ticks        <= csr_wdata;
            dfpm_pkg::CSR_HEALTH_TMO:   cfg_ff.health_timeout_ticks <= csr_wdata;
            dfpm_pkg::CSR_CLOSE_THRESH: cfg_ff.close_threshold      <= csr_wdata;
            default: ;
         endcase
      end
   end

   dfpm_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .item_accept (req_accept),
      .item        (req_data),
      .cfg         (cfg_ff),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_take) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (req_accept) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_take) begin
            rsp_data_ff <= skid_data_ff;
         end
      end else if (req_accept) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_data_ff <= result;
         end else begin
            skid_data_ff <= result;
         end
      end
   end

   `DFPM_ASSERT_SAME(a_skid_behind_out, clock, reset, skid_valid_ff, rsp_valid_ff)
   `DFPM_ASSERT_NEXT(a_stalled_accept_skids, clock, reset, req_accept && rsp_valid_ff && rsp_stall, skid_valid_ff)
   `DFPM_ASSERT_NEXT(a_accept_gives_result, clock, reset, req_accept, rsp_valid_ff)
   `DFPM_ASSERT_SAME(a_close_needs_fresh, clock, reset, rsp_valid_ff && rsp_data_ff.too_close, rsp_data_ff.fresh)

endmodule

>>> hdl/dfpm_engine.sv
module dfpm_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_accept,
   input  dfpm_pkg::req_type_type item,
   input  dfpm_pkg::cfg_type      cfg,
   output dfpm_pkg::rsp_type      result
);

   localparam logic [1:0] POS_HUNT  = 2'd0;
   localparam logic [1:0] POS_HIGH  = 2'd1;
   localparam logic [1:0] POS_LOW   = 2'd2;
   localparam logic [1:0] POS_CHECK = 2'd3;

   logic [1:0]  pos_ff, pos_in;
   logic [7:0]  high_ff, high_in;
   logic [7:0]  low_ff, low_in;
   logic [15:0] dist_ff, dist_in;
   logic        has_ff, has_in;
   logic [15:0] age_ff, age_in;
   logic [31:0] drops_ff, drops_in;
   logic        accepted;

   logic [7:0]  sum;
   logic [15:0] frame_dist;
   logic        fresh;

   assign sum        = 8'(dfpm_pkg::HEADER_BYTE + high_ff + low_ff);
   assign frame_dist = {high_ff, low_ff};

   always_comb begin
      pos_in   = pos_ff;
      high_in  = high_ff;
      low_in   = low_ff;
      dist_in  = dist_ff;
      has_in   = has_ff;
      age_in   = age_ff;
      drops_in = drops_ff;
      accepted = 1'b0;
      if (item.req_type == dfpm_pkg::REQ_TICK) begin
         if (age_ff != dfpm_pkg::AGE_MAX) begin
            age_in = 16'(age_ff + 16'd1);
         end
      end else begin
         case (pos_ff)
            POS_HUNT: begin
               if (item.byte_value == dfpm_pkg::HEADER_BYTE) begin
                  pos_in = POS_HIGH;
               end
            end
            POS_HIGH: begin
               high_in = item.byte_value;
               pos_in  = POS_LOW;
            end
            POS_LOW: begin
               low_in = item.byte_value;
               pos_in = POS_CHECK;
            end
            default: begin
               pos_in = POS_HUNT;
               // bad checksum: frame dropped silently
               if (sum == item.byte_value) begin
                  if (frame_dist >= cfg.distance_min && frame_dist <= cfg.distance_max) begin
                     dist_in  = frame_dist;
                     has_in   = 1'b1;
                     age_in   = '0;
                     accepted = 1'b1;
                  end else begin
                     drops_in = 32'(drops_ff + 32'd1);
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= POS_HUNT;
         high_ff  <= '0;
         low_ff   <= '0;
         dist_ff  <= '0;
         has_ff   <= 1'b0;
         age_ff   <= '0;
         drops_ff <= '0;
      end else if (item_accept) begin
         pos_ff   <= pos_in;
         high_ff  <= high_in;
         low_ff   <= low_in;
         dist_ff  <= dist_in;
         has_ff   <= has_in;
         age_ff   <= age_in;
         drops_ff <= drops_in;
      end
   end

   // flags reflect the state after this transaction's update
   assign fresh = has_in && (age_in <= cfg.max_age_ticks);

   always_comb begin
      result.distance       = dist_in;
      result.fresh          = fresh;
      result.too_close      = fresh && (dist_in <= cfg.close_threshold);
      result.healthy        = has_in && (age_in <= cfg.health_timeout_ticks);
      result.frame_accepted = accepted;
      result.drop_count     = drops_in;
   end

endmodule
